[hw/rtl/pps_pkg.sv]
`timescale 1ns / 1ps

package pps_pkg;

  localparam int MAX_PROCS_DEF = 16;

  localparam int ARR_W = 16;
  localparam int BUR_W = 16;
  localparam int PRI_W = 8;
  localparam int IDX_W = 4;
  localparam int RES_W = 21;
  localparam int TOT_W = 25;

  localparam int ARR_SPAN = 1 << ARR_W;

  localparam int JOB_W = ARR_W + BUR_W + PRI_W;
  localparam int DYN_W = RES_W;

endpackage

[hw/rtl/preemptive_priority_scheduler.sv]
`timescale 1ns / 1ps
// Preemptive priority scheduler.
// Input channel (in_valid/in_ready): one beat per job, taken while the block
// is loading. Jobs beyond MAX_PROCS are dropped; a beat with last_job set
// closes the set and starts scheduling. in_ready stays low from then until
// the last result of the set has been placed in the output register.
// Scheduling runs in passes. Each pass walks the stored jobs through one
// shared compare unit, one job per cycle from a RAM with registered read;
// states S_UPD1 and S_UPD2 then apply the chosen run. A pass ends with a
// job finishing, a preemption at the next arrival or an idle jump to it,
// so a set of n jobs needs at most 2n passes.
// Output channel (out_valid/out_ready): one beat per job in load order; each
// beat is prepared in states S_ORD, S_OTAT and S_OEMIT. A stalled receiver
// holds the current beat and the block waits before the next one; after the
// final beat is registered the block clears and loads the next set at once.
// Reset (rst, synchronous) empties the set, zeroes time and drops any
// pending result.
module preemptive_priority_scheduler #(
  parameter int MAX_PROCS = pps_pkg::MAX_PROCS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [pps_pkg::ARR_W-1:0] arrival_time,
  input  logic [pps_pkg::BUR_W-1:0] burst_length,
  input  logic [pps_pkg::PRI_W-1:0] priority_level,
  input  logic                      last_job,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [pps_pkg::IDX_W-1:0] job_index,
  output logic [pps_pkg::RES_W-1:0] waiting_time,
  output logic [pps_pkg::RES_W-1:0] turnaround_time,
  output logic [pps_pkg::TOT_W-1:0] total_waiting,
  output logic [pps_pkg::TOT_W-1:0] total_turnaround,
  output logic                      last_result
);
  import pps_pkg::*;

  localparam int AW     = $clog2(MAX_PROCS);
  localparam int CW     = $clog2(MAX_PROCS + 1);
  localparam int TW_RAW = $clog2(ARR_SPAN * (MAX_PROCS + 1));
  localparam int TW     = (TW_RAW > RES_W) ? TW_RAW : RES_W;

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_UPD1  = 3'd2;
  localparam logic [2:0] S_UPD2  = 3'd3;
  localparam logic [2:0] S_ORD   = 3'd4;
  localparam logic [2:0] S_OTAT  = 3'd5;
  localparam logic [2:0] S_OEMIT = 3'd6;

  logic [2:0]           state;
  logic [CW-1:0]        job_count;
  logic [CW-1:0]        jobs_done;
  logic [TW-1:0]        cur_time;
  logic [MAX_PROCS-1:0] finished;
  logic [CW-1:0]        ridx;
  logic                 dv;
  logic [AW-1:0]        didx;
  logic                 pick_v;
  logic [AW-1:0]        pick;
  logic [PRI_W-1:0]     best;
  logic [BUR_W-1:0]     pick_rem;
  logic                 have_next;
  logic [ARR_W-1:0]     next_arr;
  logic [BUR_W-1:0]     run_len;
  logic [CW-1:0]        oidx;
  logic [RES_W-1:0]     tat_r;
  logic [BUR_W-1:0]     bur_r;
  logic [TOT_W-1:0]     tw_acc;
  logic [TOT_W-1:0]     tt_acc;

  logic              job_we;
  logic [BUR_W-1:0]  bur_eff;
  logic [JOB_W-1:0]  job_wdata;
  logic [JOB_W-1:0]  job_rdata;
  logic              dyn_we;
  logic [AW-1:0]     dyn_waddr;
  logic [DYN_W-1:0]  dyn_wdata;
  logic [DYN_W-1:0]  dyn_rdata;
  logic [AW-1:0]     raddr;
  logic [ARR_W-1:0]  d_arr;
  logic [BUR_W-1:0]  d_bur;
  logic [PRI_W-1:0]  d_pri;
  logic              d_ready;
  logic [BUR_W-1:0]  rem_next;
  logic [TW-1:0]     time_next;
  logic [TW-1:0]     gap;
  logic              issue;
  logic              scan_done;
  logic              emit;
  logic              o_last;
  logic [RES_W-1:0]  wt_next;
  logic [TOT_W-1:0]  tw_next;
  logic [TOT_W-1:0]  tt_next;
  logic              job_fin;

  assign in_ready = (state == S_LOAD);

  always_comb begin
    bur_eff   = (burst_length == '0) ? BUR_W'(1) : burst_length;
    job_we    = in_valid && in_ready && (job_count != CW'(MAX_PROCS));
    job_wdata = {arrival_time, bur_eff, priority_level};
    rem_next  = pick_rem - run_len;
    time_next = cur_time + TW'(run_len);
    job_fin   = (rem_next == '0);
    dyn_we    = job_we || (state == S_UPD2);
    dyn_waddr = (state == S_UPD2) ? pick : job_count[AW-1:0];
    if (state == S_UPD2) begin
      dyn_wdata = job_fin ? time_next[RES_W-1:0] : DYN_W'(rem_next);
    end else begin
      dyn_wdata = DYN_W'(bur_eff);
    end
    raddr     = (state == S_SCAN) ? ridx[AW-1:0] : oidx[AW-1:0];
    d_arr     = job_rdata[JOB_W-1 -: ARR_W];
    d_bur     = job_rdata[PRI_W +: BUR_W];
    d_pri     = job_rdata[PRI_W-1:0];
    d_ready   = TW'(d_arr) <= cur_time;
    gap       = TW'(next_arr) - cur_time;
    issue     = (ridx != job_count);
    scan_done = !issue && !dv;
    emit      = (state == S_OEMIT) && (!out_valid || out_ready);
    o_last    = ((oidx + CW'(1)) == job_count);
    wt_next   = tat_r - RES_W'(bur_r);
    tw_next   = tw_acc + TOT_W'(wt_next);
    tt_next   = tt_acc + TOT_W'(tat_r);
  end

  pps_ram #(
    .WIDTH (JOB_W),
    .DEPTH (MAX_PROCS)
  ) u_job_ram (
    .clk   (clk),
    .we    (job_we),
    .waddr (job_count[AW-1:0]),
    .wdata (job_wdata),
    .raddr (raddr),
    .rdata (job_rdata)
  );

  pps_ram #(
    .WIDTH (DYN_W),
    .DEPTH (MAX_PROCS)
  ) u_dyn_ram (
    .clk   (clk),
    .we    (dyn_we),
    .waddr (dyn_waddr),
    .wdata (dyn_wdata),
    .raddr (raddr),
    .rdata (dyn_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      job_count <= '0;
      jobs_done <= '0;
      cur_time  <= '0;
      finished  <= '0;
      ridx      <= '0;
      dv        <= 1'b0;
      pick_v    <= 1'b0;
      have_next <= 1'b0;
      oidx      <= '0;
      tw_acc    <= '0;
      tt_acc    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (in_valid) begin
            if (job_we) begin
              job_count <= job_count + CW'(1);
            end
            if (last_job) begin
              state     <= S_SCAN;
              ridx      <= '0;
              dv        <= 1'b0;
              pick_v    <= 1'b0;
              have_next <= 1'b0;
            end
          end
        end
        S_SCAN: begin
          dv   <= issue;
          didx <= ridx[AW-1:0];
          if (issue) begin
            ridx <= ridx + CW'(1);
          end
          if (dv && !finished[didx]) begin
            if (d_ready) begin
              if (!pick_v || d_pri < best) begin
                pick_v   <= 1'b1;
                best     <= d_pri;
                pick     <= didx;
                pick_rem <= dyn_rdata[BUR_W-1:0];
              end
            end else if (!have_next || d_arr < next_arr) begin
              have_next <= 1'b1;
              next_arr  <= d_arr;
            end
          end
          if (scan_done) begin
            if (pick_v) begin
              state <= S_UPD1;
            end else begin
              // idle: jump to the earliest pending arrival and rescan
              cur_time  <= TW'(next_arr);
              ridx      <= '0;
              have_next <= 1'b0;
            end
          end
        end
        S_UPD1: begin
          if (have_next && gap < TW'(pick_rem)) begin
            run_len <= gap[BUR_W-1:0];
          end else begin
            run_len <= pick_rem;
          end
          state <= S_UPD2;
        end
        S_UPD2: begin
          cur_time <= time_next;
          if (job_fin) begin
            finished[pick] <= 1'b1;
            jobs_done      <= jobs_done + CW'(1);
          end
          if (job_fin && (jobs_done + CW'(1)) == job_count) begin
            state <= S_ORD;
            oidx  <= '0;
          end else begin
            state     <= S_SCAN;
            ridx      <= '0;
            dv        <= 1'b0;
            pick_v    <= 1'b0;
            have_next <= 1'b0;
          end
        end
        S_ORD: begin
          state <= S_OTAT;
        end
        S_OTAT: begin
          tat_r <= dyn_rdata[RES_W-1:0] - RES_W'(d_arr);
          bur_r <= d_bur;
          state <= S_OEMIT;
        end
        S_OEMIT: begin
          if (emit) begin
            job_index        <= IDX_W'(oidx);
            waiting_time     <= wt_next;
            turnaround_time  <= tat_r;
            total_waiting    <= tw_next;
            total_turnaround <= tt_next;
            last_result      <= o_last;
            if (o_last) begin
              state     <= S_LOAD;
              job_count <= '0;
              jobs_done <= '0;
              cur_time  <= '0;
              finished  <= '0;
              tw_acc    <= '0;
              tt_acc    <= '0;
            end else begin
              tw_acc <= tw_next;
              tt_acc <= tt_next;
              oidx   <= oidx + CW'(1);
              state  <= S_ORD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  a_done_bound: assert property (@(posedge clk) disable iff (rst)
    jobs_done <= job_count)
    else $error("completed jobs exceed stored jobs");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    job_count <= CW'(MAX_PROCS))
    else $error("job store overfilled");

  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_UPD1 |-> pick_rem != '0)
    else $error("picked job has no remaining service");

  a_set_clear: assert property (@(posedge clk) disable iff (rst)
    emit && o_last |=> state == S_LOAD && job_count == '0 && finished == '0 && out_valid)
    else $error("set not cleared after final result");

endmodule

[hw/rtl/pps_ram.sv]
`timescale 1ns / 1ps

module pps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
